[rtl/bccc_pkg.sv]
// Shared constants and types for the binary code coverage checker.
package bccc_pkg;

	// Default longest window, in bits.
	localparam int MAX_CODE_BITS_DEF = 16;

	// Width of the generation tag stored with each bitmap entry.
	localparam int EPOCH_W = 4;

	// Width of the code length register and its reset value.
	localparam int CODE_LEN_W = 5;
	localparam logic [CODE_LEN_W-1:0] CODE_LEN_RST = 5'd2;

	// Width of the reported distinct count.
	localparam int COUNT_W = 17;

	// Depth of the result queue in front of the output.
	localparam int OUT_DEPTH = 3;

	// One result word.
	typedef struct packed {
		logic               all_codes_seen;
		logic [COUNT_W-1:0] distinct_count;
	} result_t;

endpackage

[rtl/binary_code_coverage_check.sv]
// Sliding-window binary code coverage checker: top level.
//
// Usage: feed one bit of the string per word on the input channel
// (in_valid/in_ready, fields bit_in and start_req). Raise start_req with
// the first bit of a new string; the window, the counters and the seen
// bitmap are cleared before that bit is taken. Each input word yields one
// result word on the output channel (out_valid/out_ready): the number of
// distinct k-bit codes seen so far and whether all 2^k codes have appeared.
// The window length k is written through cfg_we/cfg_wdata while idle.
// A result word passes through the stage 1 register and then the result queue before it
// turns valid on the output. Throughput is one bit per cycle while in_ready stays high,
// set by the single read-modify-write of the bitmap memory; back-to-back
// repeats of the same code are forwarded around the memory.
// The bitmap stores a generation tag per entry, so a start costs no time.
// After reset, and again when the tag space is used up (the start that
// would follow the 14th start after a sweep), a clearing pass writes every
// entry, one per cycle, during which in_ready is low; configuration writes
// are still taken. A three-word result queue decouples the sides: when the
// receiver stalls, the queue fills and in_ready drops; nothing is lost.
module binary_code_coverage_check
	import bccc_pkg::*;
#(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CODE_LEN_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  bit_in,
	input  logic                  start_req,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  all_codes_seen,
	output logic [COUNT_W-1:0]    distinct_count
);

	localparam int AW    = MAX_CODE_BITS;
	localparam int DEPTH = 1 << AW;
	localparam int KW    = $clog2(MAX_CODE_BITS + 1);
	localparam int TW    = MAX_CODE_BITS + 1;
	localparam int QW    = $clog2(OUT_DEPTH);
	localparam int QCW   = $clog2(OUT_DEPTH + 1);
	localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [QW-1:0] QLAST = QW'(OUT_DEPTH - 1);

	// Configuration and stream state.
	logic [CODE_LEN_W-1:0] code_length_q;
	logic [AW-1:0]         window_q;
	logic [KW-1:0]         brx_q;
	logic [TW-1:0]         total_q;
	logic [EPOCH_W-1:0]    epoch_q;

	// Clearing pass.
	logic                  clr_q;
	logic [AW-1:0]         clr_addr_q;

	// Bitmap memory: one generation tag per code.
	logic [EPOCH_W-1:0]    mem [DEPTH];

	// Stage 1: lookup result.
	logic                  valid_s1;
	logic                  start_s1;
	logic                  mark_s1;
	logic                  fwd_s1;
	logic [AW-1:0]         code_s1;
	logic [EPOCH_W-1:0]    epoch_s1;
	logic [TW-1:0]         full_s1;
	logic [EPOCH_W-1:0]    rd_s1;

	// Result queue.
	result_t               q_mem [OUT_DEPTH];
	logic [QW-1:0]         q_wr_q;
	logic [QW-1:0]         q_rd_q;
	logic [QCW-1:0]        q_cnt_q;

	// Accept-side logic.
	logic                  in_acc;
	logic                  room;
	logic                  tag_full_stall;
	logic [KW-1:0]         eff_k;
	logic [AW-1:0]         win_base;
	logic [AW-1:0]         win_new;
	logic [KW-1:0]         brx_base;
	logic [KW-1:0]         brx_new;
	logic [AW-1:0]         kmask;
	logic [AW-1:0]         code;
	logic                  mark;
	logic [EPOCH_W-1:0]    epoch_new;

	// Stage 1 logic.
	logic                  hit_s1;
	logic                  newc_s1;
	logic [TW-1:0]         tot_base_s1;
	logic [TW-1:0]         tot_new_s1;
	result_t               res_s1;

	// Memory write port.
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [EPOCH_W-1:0]    mem_wdata;

	logic                  q_pop;

	// Clamp the configured length into 1..MAX_CODE_BITS.
	always_comb begin
		if (code_length_q == '0) begin
			eff_k = KW'(1);
		end else if (int'(code_length_q) > MAX_CODE_BITS) begin
			eff_k = KW'(MAX_CODE_BITS);
		end else begin
			eff_k = KW'(code_length_q);
		end
	end

	// Hold off a start when the tag space is spent; that start waits for a sweep.
	assign tag_full_stall = start_req && (epoch_q == EPOCH_MAX);
	assign room           = (QCW'(q_cnt_q) + QCW'(valid_s1)) < QCW'(OUT_DEPTH);
	assign in_ready       = !clr_q && room && !tag_full_stall;
	assign in_acc         = in_valid && in_ready;

	// Shift in the new bit and pick the low k bits as the code.
	always_comb begin
		win_base  = start_req ? '0 : window_q;
		brx_base  = start_req ? '0 : brx_q;
		win_new   = AW'({win_base, bit_in});
		brx_new   = (brx_base < KW'(MAX_CODE_BITS)) ? brx_base + KW'(1) : brx_base;
		kmask     = ~({AW{1'b1}} << eff_k);
		code      = win_new & kmask;
		mark      = brx_new >= eff_k;
		epoch_new = start_req ? epoch_q + EPOCH_W'(1) : epoch_q;
	end

	// Advance the window, counter, epoch and clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_length_q <= CODE_LEN_RST;
			window_q      <= '0;
			brx_q         <= '0;
			epoch_q       <= EPOCH_FIRST;
			clr_q         <= 1'b1;
			clr_addr_q    <= '0;
		end else begin
			if (cfg_we) begin
				code_length_q <= cfg_wdata;
			end
			if (in_acc) begin
				window_q <= win_new;
				brx_q    <= brx_new;
				epoch_q  <= epoch_new;
			end
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == {AW{1'b1}}) begin
					clr_q   <= 1'b0;
					epoch_q <= EPOCH_FIRST;
				end
			end else if (in_valid && tag_full_stall && !valid_s1) begin
				clr_q <= 1'b1;
			end
		end
	end

	// Choose the memory write: sweep first, else the stage 1 mark.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = code_s1;
		mem_wdata = epoch_s1;
		if (clr_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else if (valid_s1 && newc_s1) begin
			mem_we = 1'b1;
		end
	end

	// Bitmap memory: registered read, one write.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_s1 <= mem[code];
		end
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			start_s1 <= start_req;
			mark_s1  <= mark;
			code_s1  <= code;
			epoch_s1 <= epoch_new;
			full_s1  <= TW'(1) << eff_k;
			fwd_s1   <= valid_s1 && mark_s1 && (code_s1 == code) && !start_req;
		end
	end

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
		end
	end

	// Decide whether the code is new and update the distinct count.
	always_comb begin
		hit_s1      = (rd_s1 == epoch_s1) || fwd_s1;
		newc_s1     = mark_s1 && !hit_s1;
		tot_base_s1 = start_s1 ? '0 : total_q;
		tot_new_s1  = tot_base_s1 + TW'(newc_s1);
		res_s1.all_codes_seen = mark_s1 && (tot_new_s1 == full_s1);
		res_s1.distinct_count = COUNT_W'(tot_new_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (valid_s1) begin
			total_q <= tot_new_s1;
		end
	end

	// Result queue: push from stage 1, pop on the output handshake.
	assign q_pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			q_mem[q_wr_q] <= res_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= '0;
			q_rd_q  <= '0;
			q_cnt_q <= '0;
		end else begin
			if (valid_s1) begin
				q_wr_q <= (q_wr_q == QLAST) ? '0 : q_wr_q + QW'(1);
			end
			if (q_pop) begin
				q_rd_q <= (q_rd_q == QLAST) ? '0 : q_rd_q + QW'(1);
			end
			q_cnt_q <= q_cnt_q + QCW'(valid_s1) - QCW'(q_pop);
		end
	end

	// Drive the output word.
	assign out_valid      = q_cnt_q != '0;
	assign all_codes_seen = q_mem[q_rd_q].all_codes_seen;
	assign distinct_count = q_mem[q_rd_q].distinct_count;

endmodule

[bench/bccc_checker.sv]
// Checker for the coverage block: tracks the bit stream, predicts each result word and compares.
`timescale 1ns / 1ps

module bccc_checker
	import bccc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CODE_LEN_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  bit_in,
	input  logic                  start_req,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  all_codes_seen,
	input  logic [COUNT_W-1:0]    distinct_count,
	output int                    errors,
	output int                    pending,
	output int                    checked,
	output int                    full_hits
);

	localparam int MAXB = MAX_CODE_BITS_DEF;

	// Shadow copy of the block's register and stream state
	logic [CODE_LEN_W-1:0] code_len   = CODE_LEN_RST;
	logic [MAXB-1:0]       window     = '0;
	int unsigned           bits_seen  = 0;
	int unsigned           codes_seen = 0;
	bit                    marked[int unsigned];

	result_t coverage_due[$];
	result_t want;

	// Forget the current string
	function automatic void clear_string();
		window = '0;
		bits_seen = 0;
		codes_seen = 0;
		marked.delete();
	endfunction

	// Shift one bit in and return the coverage word it produces
	function automatic result_t coverage_after_bit(input logic b, input logic s);
		int unsigned k;
		int unsigned code;
		result_t r;
		k = (code_len == 0) ? 1 : (code_len > MAXB) ? MAXB : code_len;
		if (s)
			clear_string();
		window = {window[MAXB-2:0], b};
		if (bits_seen < MAXB)
			bits_seen++;
		if (bits_seen >= k) begin
			code = window & ((32'd1 << k) - 1);
			if (!marked.exists(code)) begin
				marked[code] = 1'b1;
				codes_seen++;
			end
		end
		r.all_codes_seen = (bits_seen >= k) && (codes_seen == (32'd1 << k));
		r.distinct_count = codes_seen[COUNT_W-1:0];
		return r;
	endfunction

	initial begin
		errors = 0;
		checked = 0;
		full_hits = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_len = CODE_LEN_RST;
			clear_string();
			coverage_due.delete();
			pending <= 0;
		end else begin
			// Compare an outgoing word against the oldest prediction
			if (out_valid && out_ready) begin
				if (coverage_due.size() == 0) begin
					$display("%0t: unexpected result word: all_codes_seen %0b, distinct_count %0d",
						$time, all_codes_seen, distinct_count);
					errors++;
				end else begin
					want = coverage_due.pop_front();
					checked++;
					if (want.all_codes_seen)
						full_hits++;
					if (all_codes_seen !== want.all_codes_seen) begin
						$display("%0t: all_codes_seen expected %0b, got %0b",
							$time, want.all_codes_seen, all_codes_seen);
						errors++;
					end
					if (distinct_count !== want.distinct_count) begin
						$display("%0t: distinct_count expected %0d, got %0d",
							$time, want.distinct_count, distinct_count);
						errors++;
					end
				end
			end
			// Predict the word for an incoming bit
			if (in_valid && in_ready)
				coverage_due.push_back(coverage_after_bit(bit_in, start_req));
			// Take a length write after the bit of this edge
			if (cfg_we)
				code_len = cfg_wdata;
			pending <= coverage_due.size();
		end
	end

endmodule

[bench/tb.sv]
// Testbench top for the coverage block: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb
	import bccc_pkg::*;
();

	localparam int RANDOM_WORDS = 1800;
	// A clearing pass, which writes every bitmap entry, moves no word
	localparam int QUIET_LIMIT  = 4 * (1 << MAX_CODE_BITS_DEF);

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CODE_LEN_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic                  bit_in;
	logic                  start_req;
	logic                  out_valid;
	logic                  out_ready;
	logic                  all_codes_seen;
	logic [COUNT_W-1:0]    distinct_count;

	int errors;
	int pending;
	int checked;
	int full_hits;
	int strings;
	int quiet;
	bit calm;

	binary_code_coverage_check DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.bit_in         (bit_in),
		.start_req      (start_req),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.all_codes_seen (all_codes_seen),
		.distinct_count (distinct_count)
	);

	bccc_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.bit_in         (bit_in),
		.start_req      (start_req),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.all_codes_seen (all_codes_seen),
		.distinct_count (distinct_count),
		.errors         (errors),
		.pending        (pending),
		.checked        (checked),
		.full_hits      (full_hits)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Draw a wait for one word; calm stretches run without gaps
	function automatic int draw_wait();
		if (calm || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// Present one bit and hold it until the block takes the word
	task automatic send_word(input logic b, input logic s);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		bit_in    <= b;
		start_req <= s;
		do @(posedge clk); while (!in_ready);
		if (s)
			strings++;
	endtask

	// Drain every result, let the pipeline settle, then write the length
	task automatic set_code_len(input logic [CODE_LEN_W-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Receiver: stall a random number of cycles before each word
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Watchdog: end the run when no word moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int r;
		int k;
		int kk;
		int nstr;
		int len;
		bit fresh;
		logic b;
		logic s;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		bit_in    = 1'b0;
		start_req = 1'b0;
		calm      = 1'b0;
		strings   = 0;
		quiet     = 0;
		sent      = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset length of two: short prefix, then every code, then one more bit
		send_word(1'b0, 1'b1);
		send_word(1'b0, 1'b0);
		send_word(1'b1, 1'b0);
		send_word(1'b1, 1'b0);
		send_word(1'b0, 1'b0);
		send_word(1'b1, 1'b0);
		// Shorten to one mid-string: the shared count is already past two
		set_code_len(5'd1);
		send_word(1'b0, 1'b0);
		send_word(1'b1, 1'b0);
		// Zero acts as length one
		set_code_len(5'd0);
		send_word(1'b1, 1'b1);
		send_word(1'b0, 1'b0);
		send_word(1'b1, 1'b0);
		// Above the widest window: clamp to sixteen, too few bits
		set_code_len(5'd31);
		send_word(1'b1, 1'b1);
		send_word(1'b1, 1'b0);
		send_word(1'b0, 1'b0);

		// Random phases: mostly short windows that can reach full coverage
		while (sent < RANDOM_WORDS) begin
			r = $urandom_range(0, 15);
			if (r <= 8)
				k = $urandom_range(1, 4);
			else if (r == 9)
				k = 0;
			else if (r == 10)
				k = 16;
			else if (r == 11)
				k = $urandom_range(17, 31);
			else if (r <= 13)
				k = $urandom_range(5, 15);
			else
				k = $urandom_range(1, 3);
			kk = (k == 0) ? 1 : (k > MAX_CODE_BITS_DEF) ? MAX_CODE_BITS_DEF : k;
			set_code_len(k[CODE_LEN_W-1:0]);
			calm = ($urandom_range(0, 4) == 0);
			nstr = $urandom_range(1, 4);
			for (int n = 0; n < nstr; n++) begin
				// Most strings open with a start; the rest carry on the old one
				fresh = ($urandom_range(0, 5) != 0);
				if (kk <= 4)
					len = $urandom_range((1 << kk) + kk, 4 * (1 << kk) + kk);
				else if (kk == 16)
					len = $urandom_range(10, 40);
				else
					len = $urandom_range(1, 40);
				for (int i = 0; i < len; i++) begin
					b = $urandom_range(0, 1);
					s = (i == 0 && fresh) || ($urandom_range(0, 63) == 0);
					send_word(b, s);
					sent++;
				end
			end
		end

		// Drain and settle
		in_valid <= 1'b0;
		calm = 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Checked %0d result words over %0d started strings and several window lengths,",
			checked, strings);
		$display("%0d of them reporting every code of the window seen.", full_hits);
		if (errors == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
